// ===== hw/rtl/shortest_arc_quaternion_defines.svh =====
// assertion helpers for the checker file
`ifndef SHORTEST_ARC_QUATERNION_DEFINES_SVH
`define SHORTEST_ARC_QUATERNION_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SAQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define SAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/saq_pkg.sv =====
package saq_pkg;

    // the largest scaled vector component sits in [2^30, 2^31) in magnitude
    localparam int MAG_W       = 32;
    localparam int RAD_W       = 64;
    localparam int ROOT_W      = 33;
    localparam int REM_W       = 36;
    localparam int SQRT_STEPS  = RAD_W / 2;
    localparam int SHIFT_STEPS = 5;

    typedef logic [RAD_W-1:0]  t_rad;
    typedef logic [ROOT_W-1:0] t_root;

endpackage

// ===== hw/rtl/shortest_arc_quaternion.sv =====
// shortest-arc rotation quaternion between two integer 3-d vectors
// throughput: one transaction per cycle while o_ready is high; each normalize/divide unit is fully pipelined,
//   43 + FRACTION_BITS + 6 stages deep (32 square-root stages, one divide stage per quotient bit)
// a one-entry output register plus one skid entry keeps o_ready high while one result waits
// reset: synchronous active-low i_rst_n clears all valid bits; payload is not reset
module shortest_arc_quaternion #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS   = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [COMPONENT_WIDTH-1:0] i_src_x,
    input  logic signed [COMPONENT_WIDTH-1:0] i_src_y,
    input  logic signed [COMPONENT_WIDTH-1:0] i_src_z,
    input  logic signed [COMPONENT_WIDTH-1:0] i_dst_x,
    input  logic signed [COMPONENT_WIDTH-1:0] i_dst_y,
    input  logic signed [COMPONENT_WIDTH-1:0] i_dst_z,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [FRACTION_BITS+1:0]   o_quat_w,
    output logic signed [FRACTION_BITS+1:0]   o_quat_x,
    output logic signed [FRACTION_BITS+1:0]   o_quat_y,
    output logic signed [FRACTION_BITS+1:0]   o_quat_z,
    output logic                              o_opposite_case,
    output logic                              o_degenerate
);
    import saq_pkg::*;

    localparam int F  = FRACTION_BITS;
    // quotient width: covers cross/s even near the half-turn threshold
    localparam int QW = F + 6;
    // numerator width: scaled component * 2^F, or an exact cross product
    localparam int NW = (F + 33 > 2 * F + 5) ? F + 33 : 2 * F + 5;
    localparam int UW = F + 2;          // unit vector component
    localparam int PW = 2 * UW;         // product of two unit components
    localparam int OW = F + 2;          // output component

    localparam longint ONE     = longint'(1) << (2 * F);
    localparam longint OPP_THR = -ONE + (ONE + 500) / 1000;   // cosine near -1
    localparam longint AX_THR  = (ONE + 5000) / 10000;        // short first axis
    localparam logic signed [QW:0] LIM = (QW+1)'(1) << F;

    typedef struct packed {
        logic                deg;
        logic [2:0][UW-1:0]  ua;
        logic [8:0][PW-1:0]  p;
        logic [1:0][PW-1:0]  asq;
    } t_mid0;

    typedef struct packed {
        logic                deg;
        logic                opp;
        logic                short_ax;
        logic [2:0][UW-1:0]  ua;
        logic [PW+1:0]       c;
        logic [2:0][PW:0]    cr;
    } t_mid1;

    typedef struct packed {
        logic [OW-1:0] w;
        logic [OW-1:0] x;
        logic [OW-1:0] y;
        logic [OW-1:0] z;
        logic          opp;
        logic          deg;
    } t_res;

    function automatic logic [OW-1:0] f_clamp(input logic signed [QW:0] v);
        priority if (v > LIM) begin
            return OW'(LIM);
        end else if (v < -LIM) begin
            return OW'(-LIM);
        end else begin
            return v[OW-1:0];
        end
    endfunction

    // whole pipeline advances unless the skid entry is occupied
    logic w_en;
    logic r_kv;
    assign w_en    = !r_kv;
    assign o_ready = w_en;

    // normalize source and destination in parallel
    logic [2:0][NW-1:0] w_src;
    logic [2:0][NW-1:0] w_dst;

    always_comb begin
        w_src[0] = NW'(i_src_x);
        w_src[1] = NW'(i_src_y);
        w_src[2] = NW'(i_src_z);
        w_dst[0] = NW'(i_dst_x);
        w_dst[1] = NW'(i_dst_y);
        w_dst[2] = NW'(i_dst_z);
    end

    logic              w_av;
    logic              w_bv;
    logic              w_az;
    logic              w_bz;
    logic [2:0][QW:0]  w_ua;
    logic [2:0][QW:0]  w_ub;

    saq_unit #(.FB(F), .NW(NW), .QW(QW), .SW(1)) u_src (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_direct (1'b0),
        .i_comp   (w_src),
        .i_rad    ('0),
        .i_side   (1'b0),
        .o_valid  (w_av),
        .o_zero   (w_az),
        .o_root   (),
        .o_quo    (w_ua),
        .o_side   ()
    );

    saq_unit #(.FB(F), .NW(NW), .QW(QW), .SW(1)) u_dst (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_direct (1'b0),
        .i_comp   (w_dst),
        .i_rad    ('0),
        .i_side   (1'b0),
        .o_valid  (w_bv),
        .o_zero   (w_bz),
        .o_root   (),
        .o_quo    (w_ub),
        .o_side   ()
    );

    // stage m0: every product of a source and a destination unit component, plus a1 and a2 squared
    logic  r_m0v;
    t_mid0 r_m0;
    t_mid0 n_m0;
    logic signed [UW-1:0] a0, a1, a2, b0, b1, b2;

    always_comb begin
        a0 = w_ua[0][UW-1:0];
        a1 = w_ua[1][UW-1:0];
        a2 = w_ua[2][UW-1:0];
        b0 = w_ub[0][UW-1:0];
        b1 = w_ub[1][UW-1:0];
        b2 = w_ub[2][UW-1:0];
        n_m0.deg    = w_az | w_bz;
        n_m0.ua     = {a2, a1, a0};
        n_m0.p[0]   = PW'(a0 * b0);
        n_m0.p[1]   = PW'(a1 * b1);
        n_m0.p[2]   = PW'(a2 * b2);
        n_m0.p[3]   = PW'(a1 * b2);
        n_m0.p[4]   = PW'(a2 * b1);
        n_m0.p[5]   = PW'(a2 * b0);
        n_m0.p[6]   = PW'(a0 * b2);
        n_m0.p[7]   = PW'(a0 * b1);
        n_m0.p[8]   = PW'(a1 * b0);
        n_m0.asq[0] = PW'(a1 * a1);
        n_m0.asq[1] = PW'(a2 * a2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m0v <= 1'b0;
        end else if (w_en) begin
            r_m0v <= w_av & w_bv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m0 <= n_m0;
        end
    end

    // stage m1: cosine, cross product, case tests
    logic  r_m1v;
    t_mid1 r_m1;
    t_mid1 n_m1;
    logic signed [PW:0] v_axl;

    always_comb begin
        n_m1.deg   = r_m0.deg;
        n_m1.ua    = r_m0.ua;
        n_m1.c     = (PW+2)'($signed(r_m0.p[0])) + (PW+2)'($signed(r_m0.p[1]))
                     + (PW+2)'($signed(r_m0.p[2]));
        n_m1.cr[0] = (PW+1)'($signed(r_m0.p[3])) - (PW+1)'($signed(r_m0.p[4]));
        n_m1.cr[1] = (PW+1)'($signed(r_m0.p[5])) - (PW+1)'($signed(r_m0.p[6]));
        n_m1.cr[2] = (PW+1)'($signed(r_m0.p[7])) - (PW+1)'($signed(r_m0.p[8]));
        v_axl      = (PW+1)'($signed(r_m0.asq[0])) + (PW+1)'($signed(r_m0.asq[1]));
        n_m1.opp   = !r_m0.deg && (longint'($signed(n_m1.c)) < OPP_THR);
        n_m1.short_ax = longint'(v_axl) < AX_THR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1v <= 1'b0;
        end else if (w_en) begin
            r_m1v <= r_m0v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1 <= n_m1;
        end
    end

    // shared unit: normalizes the half-turn axis, or divides the cross
    // product by s = sqrt(2*(1+c)) in the normal case
    logic [2:0][NW-1:0] w_ccomp;
    t_rad               w_crad;

    always_comb begin
        w_crad = RAD_W'((ONE + longint'($signed(r_m1.c))) * 2);
        if (r_m1.opp) begin
            if (r_m1.short_ax) begin
                w_ccomp[0] = -NW'($signed(r_m1.ua[2]));
                w_ccomp[1] = '0;
                w_ccomp[2] = NW'($signed(r_m1.ua[0]));
            end else begin
                w_ccomp[0] = '0;
                w_ccomp[1] = NW'($signed(r_m1.ua[2]));
                w_ccomp[2] = -NW'($signed(r_m1.ua[1]));
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                w_ccomp[i] = NW'($signed(r_m1.cr[i]));
            end
        end
    end

    logic             w_cv;
    t_root            w_croot;
    logic [2:0][QW:0] w_cq;
    logic [1:0]       w_cside;

    saq_unit #(.FB(F), .NW(NW), .QW(QW), .SW(2)) u_arc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_m1v),
        .i_direct (!r_m1.opp),
        .i_comp   (w_ccomp),
        .i_rad    (w_crad),
        .i_side   ({r_m1.opp, r_m1.deg}),
        .o_valid  (w_cv),
        .o_zero   (),
        .o_root   (w_croot),
        .o_quo    (w_cq),
        .o_side   (w_cside)
    );

    // result assembly; a zero root means a zero axis or zero s, giving zero x/y/z
    t_res n_res;
    logic w_rzero;

    always_comb begin
        w_rzero   = (w_croot == '0);
        n_res.opp = w_cside[1];
        n_res.deg = w_cside[0];
        n_res.x   = w_rzero ? '0 : f_clamp(w_cq[0]);
        n_res.y   = w_rzero ? '0 : f_clamp(w_cq[1]);
        n_res.z   = w_rzero ? '0 : f_clamp(w_cq[2]);
        // s stays below about 2^(F+1) here, so the cast keeps all of (s+1)/2
        n_res.w   = f_clamp((QW+1)'(t_root'(w_croot + 1'b1) >> 1));
        if (w_cside[0]) begin
            n_res.w = OW'(LIM);
            n_res.x = '0;
            n_res.y = '0;
            n_res.z = '0;
        end else if (w_cside[1]) begin
            n_res.w = '0;
        end
    end

    // output register with one skid entry
    logic r_ov;
    t_res r_o;
    t_res r_k;
    logic w_ofree;
    assign w_ofree = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_kv <= 1'b0;
        end else begin
            if (w_ofree) begin
                if (r_kv) begin
                    r_o  <= r_k;
                    r_ov <= 1'b1;
                    r_kv <= 1'b0;
                end else begin
                    r_o  <= n_res;
                    r_ov <= w_cv;
                end
            end else if (w_cv && !r_kv) begin
                r_k  <= n_res;
                r_kv <= 1'b1;
            end
        end
    end

    assign o_valid         = r_ov;
    assign o_quat_w        = r_o.w;
    assign o_quat_x        = r_o.x;
    assign o_quat_y        = r_o.y;
    assign o_quat_z        = r_o.z;
    assign o_opposite_case = r_o.opp;
    assign o_degenerate    = r_o.deg;

endmodule

// ===== hw/rtl/saq_unit.sv =====
module saq_unit #(
    parameter int FB = 14,
    parameter int NW = 47,
    parameter int QW = 20,
    parameter int SW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic                  i_direct,
    input  logic [2:0][NW-1:0]    i_comp,
    input  saq_pkg::t_rad         i_rad,
    input  logic [SW-1:0]         i_side,
    output logic                  o_valid,
    output logic                  o_zero,
    output saq_pkg::t_root        o_root,
    output logic [2:0][QW:0]      o_quo,
    output logic [SW-1:0]         o_side
);
    import saq_pkg::*;

    localparam int DW = (NW + 1 > ROOT_W + QW) ? NW + 1 : ROOT_W + QW;

    typedef struct packed {
        logic                direct;
        logic                zero;
        logic [SW-1:0]       side;
        logic [MAG_W-1:0]    m;
        t_rad                rad;
        logic [2:0][NW-1:0]  comp;
    } t_front;

    typedef struct packed {
        logic                zero;
        logic [SW-1:0]       side;
        t_rad                x;
        logic [REM_W-1:0]    rem;
        t_root               root;
        logic [2:0][NW-1:0]  num;
    } t_sqst;

    typedef struct packed {
        logic                zero;
        logic [SW-1:0]       side;
        t_root               root;
        logic [2:0]          neg;
        logic [2:0][DW-1:0]  rem;
        logic [2:0][QW-1:0]  q;
    } t_dvst;

    function automatic logic [NW-1:0] f_abs(input logic [NW-1:0] v);
        return v[NW-1] ? (~v + 1'b1) : v;
    endfunction

    // front: magnitude or, then leading-one alignment
    logic [SHIFT_STEPS:0] r_fv;
    t_front               r_f [0:SHIFT_STEPS];
    t_front               n_f0;
    logic [NW-1:0]        w_abs0 [0:2];

    always_comb begin
        n_f0.direct = i_direct;
        n_f0.side   = i_side;
        n_f0.rad    = i_rad;
        n_f0.comp   = i_comp;
        for (int i = 0; i < 3; i++) begin
            w_abs0[i] = f_abs(i_comp[i]);
        end
        n_f0.m    = w_abs0[0][MAG_W-1:0] | w_abs0[1][MAG_W-1:0] | w_abs0[2][MAG_W-1:0];
        n_f0.zero = (n_f0.m == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv[0] <= 1'b0;
        end else if (i_en) begin
            r_fv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f[0] <= n_f0;
        end
    end

    for (genvar j = 1; j <= SHIFT_STEPS; j++) begin : g_shift
        localparam int S = 1 << (SHIFT_STEPS - j);
        logic   hit;
        t_front n_f;

        assign hit = !r_f[j-1].direct && !r_f[j-1].m[MAG_W-1]
                     && (r_f[j-1].m[MAG_W-2 -: S] == '0);

        always_comb begin
            n_f = r_f[j-1];
            if (hit) begin
                n_f.m = r_f[j-1].m << S;
                for (int i = 0; i < 3; i++) begin
                    n_f.comp[i] = r_f[j-1].comp[i] << S;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fv[j] <= 1'b0;
            end else if (i_en) begin
                r_fv[j] <= r_fv[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_f[j] <= n_f;
            end
        end
    end

    // squares of the aligned components
    logic                   r_sv;
    t_front                 r_s;
    logic [2:0][RAD_W-1:0]  r_sq;
    logic [2:0][MAG_W-1:0]  w_mag;
    logic [NW-1:0]          w_absf [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_absf[i] = f_abs(r_f[SHIFT_STEPS].comp[i]);
            w_mag[i]  = w_absf[i][MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (i_en) begin
            r_sv <= r_fv[SHIFT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= r_f[SHIFT_STEPS];
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= w_mag[i] * w_mag[i];
            end
        end
    end

    // square root, one result bit per stage
    logic [SQRT_STEPS:0] r_qv;
    t_sqst               r_q [0:SQRT_STEPS];
    t_sqst               n_q0;

    always_comb begin
        n_q0.zero = r_s.zero;
        n_q0.side = r_s.side;
        n_q0.rem  = '0;
        n_q0.root = '0;
        n_q0.x    = r_s.direct ? r_s.rad : (r_sq[0] + r_sq[1] + r_sq[2]);
        for (int i = 0; i < 3; i++) begin
            n_q0.num[i] = r_s.direct ? r_s.comp[i] : (r_s.comp[i] << FB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv[0] <= 1'b0;
        end else if (i_en) begin
            r_qv[0] <= r_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= n_q0;
        end
    end

    for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
        logic [REM_W-1:0] remn;
        logic [REM_W-1:0] trial;
        t_sqst            n_q;

        assign remn  = {r_q[k-1].rem[REM_W-3:0], r_q[k-1].x[RAD_W-1 -: 2]};
        assign trial = REM_W'({r_q[k-1].root, 2'b01});

        always_comb begin
            n_q   = r_q[k-1];
            n_q.x = r_q[k-1].x << 2;
            if (remn >= trial) begin
                n_q.rem  = remn - trial;
                n_q.root = {r_q[k-1].root[ROOT_W-2:0], 1'b1};
            end else begin
                n_q.rem  = remn;
                n_q.root = {r_q[k-1].root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qv[k] <= 1'b0;
            end else if (i_en) begin
                r_qv[k] <= r_qv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k] <= n_q;
            end
        end
    end

    // round root to nearest
    logic  r_rv;
    t_sqst r_r;
    t_sqst n_r;

    always_comb begin
        n_r = r_q[SQRT_STEPS];
        if (r_q[SQRT_STEPS].rem > REM_W'(r_q[SQRT_STEPS].root)) begin
            n_r.root = r_q[SQRT_STEPS].root + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else if (i_en) begin
            r_rv <= r_qv[SQRT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r <= n_r;
        end
    end

    // divide |num| + root/2 by root, one quotient bit per stage
    logic [QW:0] r_dv;
    t_dvst       r_d [0:QW];
    t_dvst       n_d0;

    always_comb begin
        n_d0.zero = r_r.zero;
        n_d0.side = r_r.side;
        n_d0.root = r_r.root;
        n_d0.q    = '0;
        for (int i = 0; i < 3; i++) begin
            n_d0.neg[i] = r_r.num[i][NW-1];
            n_d0.rem[i] = DW'(f_abs(r_r.num[i])) + DW'(r_r.root >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (i_en) begin
            r_dv[0] <= r_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= n_d0;
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_div
        localparam int B = QW - j;
        logic [DW-1:0] dsh;
        t_dvst         n_d;

        assign dsh = DW'(r_d[j-1].root) << B;

        always_comb begin
            n_d = r_d[j-1];
            for (int i = 0; i < 3; i++) begin
                if (r_d[j-1].rem[i] >= dsh) begin
                    n_d.rem[i]  = r_d[j-1].rem[i] - dsh;
                    n_d.q[i][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j] <= 1'b0;
            end else if (i_en) begin
                r_dv[j] <= r_dv[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[j] <= n_d;
            end
        end
    end

    // restore signs
    logic              r_ov;
    logic [2:0][QW:0]  r_oq;
    t_root             r_oroot;
    logic [SW-1:0]     r_oside;
    logic              r_ozero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oroot <= r_d[QW].root;
            r_oside <= r_d[QW].side;
            r_ozero <= r_d[QW].zero;
            for (int i = 0; i < 3; i++) begin
                r_oq[i] <= r_d[QW].neg[i] ? -((QW+1)'(r_d[QW].q[i]))
                                          : (QW+1)'(r_d[QW].q[i]);
            end
        end
    end

    assign o_valid = r_ov;
    assign o_zero  = r_ozero;
    assign o_root  = r_oroot;
    assign o_quo   = r_oq;
    assign o_side  = r_oside;

endmodule

// ===== hw/rtl/saq_checker.sv =====
`include "shortest_arc_quaternion_defines.svh"

module saq_checker #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS   = 14
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic signed [FRACTION_BITS+1:0] o_quat_w,
    input logic signed [FRACTION_BITS+1:0] o_quat_x,
    input logic signed [FRACTION_BITS+1:0] o_quat_y,
    input logic signed [FRACTION_BITS+1:0] o_quat_z,
    input logic                            o_opposite_case,
    input logic                            o_degenerate
);
    localparam logic signed [FRACTION_BITS+1:0] UNIT = (FRACTION_BITS+2)'(1) << FRACTION_BITS;

    // a stalled result transaction holds
    `SAQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_quat_w) && $stable(o_quat_x) && $stable(o_quat_y) && $stable(o_quat_z) && $stable(o_opposite_case) && $stable(o_degenerate))

    // zero-length input gives the identity and never the half-turn flag
    `SAQ_ASSERT_SAME(a_deg_identity, i_clk, i_rst_n, o_valid && o_degenerate, o_quat_w == UNIT && o_quat_x == 0 && o_quat_y == 0 && o_quat_z == 0 && !o_opposite_case)

    // half-turn has no scalar part
    `SAQ_ASSERT_SAME(a_opp_w_zero, i_clk, i_rst_n, o_valid && o_opposite_case, o_quat_w == 0)

    // normal case scalar part lies in [0, 1]
    `SAQ_ASSERT_SAME(a_norm_w_range, i_clk, i_rst_n, o_valid && !o_opposite_case && !o_degenerate, o_quat_w >= 0 && o_quat_w <= UNIT)

endmodule

bind shortest_arc_quaternion saq_checker #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH),
    .FRACTION_BITS   (FRACTION_BITS)
) u_saq_checker (.*);

// ===== verif/tb_shortest_arc_quaternion.sv =====
`timescale 1ns / 1ps

module tb_shortest_arc_quaternion;

    localparam int CW = 16;
    localparam int FB = 14;
    localparam int QW = FB + 2;
    localparam int CLK_HALF = 4;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 300;
    localparam int STALL_LIMIT = 5000;   // cycles with no transaction at all
    localparam int LONG_HOLD = 400;
    localparam int MAX_REPORTS = 10;

    // one pair of input vectors
    typedef struct {
        logic signed [CW-1:0] sx, sy, sz, dx, dy, dz;
    } vec_pair_t;

    // one rotation quaternion plus flags
    typedef struct {
        logic signed [QW-1:0] w, x, y, z;
        logic                 opp, deg;
    } rot_quat_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [CW-1:0] i_src_x, i_src_y, i_src_z, i_dst_x, i_dst_y, i_dst_z;
    logic               o_valid;
    logic               i_ready;
    logic signed [QW-1:0] o_quat_w, o_quat_x, o_quat_y, o_quat_z;
    logic               o_opposite_case;
    logic               o_degenerate;

    shortest_arc_quaternion #(
        .COMPONENT_WIDTH(CW),
        .FRACTION_BITS  (FB)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_src_x        (i_src_x),
        .i_src_y        (i_src_y),
        .i_src_z        (i_src_z),
        .i_dst_x        (i_dst_x),
        .i_dst_y        (i_dst_y),
        .i_dst_z        (i_dst_z),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_quat_w       (o_quat_w),
        .o_quat_x       (o_quat_x),
        .o_quat_y       (o_quat_y),
        .o_quat_z       (o_quat_z),
        .o_opposite_case(o_opposite_case),
        .o_degenerate   (o_degenerate)
    );

    // vector pairs waiting to be driven, quaternions waiting to come out
    vec_pair_t pending_pairs[$];
    rot_quat_t expected_quats[$];

    int  sender_idle_pct = 0;
    int  receiver_stall_pct = 0;
    bit  sender_paused = 0;
    bit  hold_req = 0;
    bit  hold_ack = 0;
    int  hold_left = 0;
    bit  pair_taken = 0;
    int  mismatch_count = 0;
    int  quiet_cycles = 0;

    // free-running clock
    initial begin
        i_clk = 0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // predictor arithmetic
    // ---------------------------------------------------------------

    // square root rounded to nearest
    function automatic longint unsigned root_nearest(input longint unsigned x);
        longint unsigned rem, res, bitv;
        rem = x;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        if (x - res * res > res) res++;
        return res;
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // quotient rounded half away from zero, divisor positive
    function automatic longint div_round(input longint n, input longint unsigned d);
        longint unsigned q;
        q = (magnitude(n) + d / 2) / d;
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    // scale to unit length with FB fraction bits; 0 for the zero vector
    function automatic bit to_unit(input longint v[3], output longint u[3]);
        longint unsigned m, sq, r;
        longint w[3];
        m = magnitude(v[0]);
        if (magnitude(v[1]) > m) m = magnitude(v[1]);
        if (magnitude(v[2]) > m) m = magnitude(v[2]);
        for (int i = 0; i < 3; i++) u[i] = 0;
        if (m == 0) return 0;
        for (int i = 0; i < 3; i++) w[i] = v[i];
        while (m < (64'd1 << 30)) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) w[i] *= 2;
        end
        sq = 0;
        for (int i = 0; i < 3; i++) sq += magnitude(w[i]) * magnitude(w[i]);
        r = root_nearest(sq);
        for (int i = 0; i < 3; i++) u[i] = div_round(w[i] * (64'sd1 << FB), r);
        return 1;
    endfunction

    function automatic logic signed [QW-1:0] clamp_q(input longint v);
        longint lim;
        lim = 64'sd1 << FB;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v[QW-1:0];
    endfunction

    // shortest-arc quaternion from src onto dst
    function automatic rot_quat_t arc_quat(input vec_pair_t p);
        longint a[3], b[3], ua[3], ub[3], ax[3], un[3], cr[3], q[4];
        longint one, c;
        longint unsigned s;
        bit ok_a, ok_b;
        rot_quat_t r;
        one = 64'sd1 << (2 * FB);
        a[0] = p.sx; a[1] = p.sy; a[2] = p.sz;
        b[0] = p.dx; b[1] = p.dy; b[2] = p.dz;
        for (int i = 0; i < 4; i++) q[i] = 0;
        r.opp = 0;
        r.deg = 0;
        ok_a = to_unit(a, ua);
        ok_b = to_unit(b, ub);
        if (!ok_a || !ok_b) begin
            // zero-length input gives the identity
            r.deg = 1;
            q[0] = 64'sd1 << FB;
        end else begin
            c = ua[0] * ub[0] + ua[1] * ub[1] + ua[2] * ub[2];
            if (c < -one + (one + 500) / 1000) begin
                // nearly opposite: half turn about src cross x, or src cross y
                r.opp = 1;
                ax[0] = 0; ax[1] = ua[2]; ax[2] = -ua[1];
                if (ua[1] * ua[1] + ua[2] * ua[2] < (one + 5000) / 10000) begin
                    ax[0] = -ua[2]; ax[1] = 0; ax[2] = ua[0];
                end
                void'(to_unit(ax, un));
                q[1] = un[0]; q[2] = un[1]; q[3] = un[2];
            end else begin
                s = root_nearest(2 * longint'(one + c));
                cr[0] = ua[1] * ub[2] - ua[2] * ub[1];
                cr[1] = ua[2] * ub[0] - ua[0] * ub[2];
                cr[2] = ua[0] * ub[1] - ua[1] * ub[0];
                q[0] = longint'((s + 1) >> 1);
                if (s != 0)
                    for (int i = 0; i < 3; i++) q[i + 1] = div_round(cr[i], s);
            end
        end
        r.w = clamp_q(q[0]);
        r.x = clamp_q(q[1]);
        r.y = clamp_q(q[2]);
        r.z = clamp_q(q[3]);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // driver: new pair offered at the falling edge once the last one went in
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || pair_taken) begin
            if (pending_pairs.size() != 0 && !sender_paused &&
                $urandom_range(99) >= sender_idle_pct) begin
                vec_pair_t p;
                p = pending_pairs.pop_front();
                i_valid <= 1'b1;
                i_src_x <= p.sx; i_src_y <= p.sy; i_src_z <= p.sz;
                i_dst_x <= p.dx; i_dst_y <= p.dy; i_dst_z <= p.dz;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off counted here
    always @(negedge i_clk) begin
        if (hold_req && !hold_ack) begin
            hold_ack = 1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // input side: predict each accepted transaction
    always @(posedge i_clk) begin
        vec_pair_t p;
        pair_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            p.sx = i_src_x; p.sy = i_src_y; p.sz = i_src_z;
            p.dx = i_dst_x; p.dy = i_dst_y; p.dz = i_dst_z;
            expected_quats.push_back(arc_quat(p));
        end
    end

    // monitor: compare each output transaction with the oldest prediction
    always @(posedge i_clk) begin
        rot_quat_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_quats.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected output transaction at %0t", $realtime);
            end else begin
                e = expected_quats.pop_front();
                if (o_quat_w !== e.w || o_quat_x !== e.x || o_quat_y !== e.y ||
                    o_quat_z !== e.z || o_opposite_case !== e.opp ||
                    o_degenerate !== e.deg) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch at %0t: exp w=%0d x=%0d y=%0d z=%0d opp=%0b deg=%0b",
                                 $realtime, e.w, e.x, e.y, e.z, e.opp, e.deg,
                                 " got w=%0d x=%0d y=%0d z=%0d opp=%0b deg=%0b",
                                 o_quat_w, o_quat_x, o_quat_y, o_quat_z,
                                 o_opposite_case, o_degenerate);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("shortest_arc_quaternion regression: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    function automatic vec_pair_t mk(input int sx, sy, sz, dx, dy, dz);
        vec_pair_t p;
        p.sx = CW'(sx); p.sy = CW'(sy); p.sz = CW'(sz);
        p.dx = CW'(dx); p.dy = CW'(dy); p.dz = CW'(dz);
        return p;
    endfunction

    function automatic logic signed [CW-1:0] rnd_comp(input int kind);
        case (kind)
            0: return CW'($urandom);
            1: return CW'(int'($urandom_range(15)) - 8);
            2: return CW'(int'($urandom_range(511)) - 256);
            default: return ($urandom_range(1) != 0) ? CW'(-32768) : CW'(32767);
        endcase
    endfunction

    function automatic logic signed [CW-1:0] neg_noisy(input logic signed [CW-1:0] v);
        int t;
        t = -int'(v) + int'($urandom_range(6)) - 3;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return CW'(t);
    endfunction

    function automatic vec_pair_t rnd_pair();
        vec_pair_t p;
        int kind, mode;
        kind = $urandom_range(3);
        p.sx = rnd_comp(kind); p.sy = rnd_comp(kind); p.sz = rnd_comp(kind);
        mode = $urandom_range(9);
        if (mode < 2) begin
            // nearly opposite, exercising the half-turn path
            p.dx = neg_noisy(p.sx); p.dy = neg_noisy(p.sy); p.dz = neg_noisy(p.sz);
        end else if (mode == 2) begin
            // source close to the x axis, so the y-axis fallback is taken
            p.sx = rnd_comp(0);
            p.sy = CW'(int'($urandom_range(3)) - 1);
            p.sz = CW'(int'($urandom_range(3)) - 1);
            p.dx = neg_noisy(p.sx); p.dy = neg_noisy(p.sy); p.dz = neg_noisy(p.sz);
        end else if (mode == 3) begin
            p.dx = p.sx; p.dy = p.sy; p.dz = p.sz;
        end else if (mode == 4 && $urandom_range(3) == 0) begin
            p.dx = 0; p.dy = 0; p.dz = 0;
        end else begin
            kind = $urandom_range(3);
            p.dx = rnd_comp(kind); p.dy = rnd_comp(kind); p.dz = rnd_comp(kind);
        end
        return p;
    endfunction

    task automatic drain_all();
        wait (pending_pairs.size() == 0 && !i_valid && expected_quats.size() == 0);
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        {i_src_x, i_src_y, i_src_z, i_dst_x, i_dst_y, i_dst_z} = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1;

        // directed corners
        pending_pairs.push_back(mk(0, 0, 0, 1, 2, 3));                 // zero source
        pending_pairs.push_back(mk(4, 5, 6, 0, 0, 0));                 // zero destination
        pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(mk(1, 0, 0, 1, 0, 0));                 // identical
        pending_pairs.push_back(mk(1, 0, 0, -1, 0, 0));                // opposite along x
        pending_pairs.push_back(mk(0, 1, 0, 0, -1, 0));                // opposite along y
        pending_pairs.push_back(mk(0, 0, 1, 0, 0, -1));
        pending_pairs.push_back(mk(32767, 32767, 32767, -32768, -32768, -32768));
        pending_pairs.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768));
        pending_pairs.push_back(mk(-32768, 0, 0, 32767, 0, 0));
        pending_pairs.push_back(mk(32767, 1, 0, -32768, 0, 1));        // tiny cross, fallback
        pending_pairs.push_back(mk(1, 0, 0, 0, 1, 0));                 // right angle
        pending_pairs.push_back(mk(0, 0, 1, 1, 0, 0));
        pending_pairs.push_back(mk(32767, -32768, 32767, -32768, 32767, -32768));
        pending_pairs.push_back(mk(1000, 20, 0, -1000, -19, 1));       // near opposite
        pending_pairs.push_back(mk(-1, -1, -1, 1, 1, 1));
        pending_pairs.push_back(mk(-1, 0, 0, 32767, 0, 0));
        pending_pairs.push_back(mk(3, -4, 12, -3, 4, -12));
        pending_pairs.push_back(mk(32767, 0, 0, 0, 0, 32767));
        pending_pairs.push_back(mk(-32768, 32767, 0, 32767, -32768, 0));
        drain_all();

        // idle phases: none, sender, receiver, both
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = (ph == 1) ? 84 : (ph == 3) ? 18 : 0;
            receiver_stall_pct = (ph == 2) ? 84 : (ph == 3) ? 18 : 0;
            for (int n = 0; n < 120; n++) pending_pairs.push_back(rnd_pair());
            drain_all();
        end

        // long receiver hold-off with the sender streaming, more transactions
        // than the pipeline holds, so the block backs up and drops o_ready
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_req = 1;
        for (int n = 0; n < 200; n++) pending_pairs.push_back(rnd_pair());
        wait (pending_pairs.size() == 0);

        // sender pauses until every expected result is out, then resumes
        sender_paused = 1;
        wait (expected_quats.size() == 0);
        sender_paused = 0;
        for (int n = 0; n < 30; n++) pending_pairs.push_back(rnd_pair());
        drain_all();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_quats.size() == 0)
            $display("shortest_arc_quaternion regression: pass");
        else
            $display("shortest_arc_quaternion regression: fail");
        $finish;
    end

endmodule
